### design/assert_macros.svh
// Assertion macros used by the top module of the matrix multiply-accumulate block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define DMMA_ASSERT(name, clk, rstn, prop) \
    name: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");
`define DMMA_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define DMMA_ASSERT(name, clk, rstn, prop)
`define DMMA_ASSERT_NEXT(name, clk, rstn, ante, cons)
`endif
`endif

### design/dmma_pkg.sv
// Types, constants and helper functions for the matrix multiply-accumulate block.
`default_nettype none
package dmma_pkg;

    localparam int MAX_N = 8;
    localparam int DEPTH = MAX_N * MAX_N;
    localparam int AW    = $clog2(DEPTH);
    localparam int IW    = $clog2(MAX_N);

    localparam logic [63:0] DEF_NAN  = 64'hFFF8_0000_0000_0000;
    localparam logic [63:0] QNAN_BIT = 64'h0008_0000_0000_0000;

    typedef enum logic [3:0] {
        ST_IDLE, ST_RDC, ST_LDC, ST_RDAB, ST_MUL, ST_MWAIT, ST_ADD, ST_AWAIT, ST_OUT
    } t_state;

    typedef enum logic [3:0] {
        FS_IDLE, FS_MUL, FS_ALIGN, FS_SUM, FS_NORM, FS_DENORM, FS_ROUND, FS_DONE
    } t_fp_state;

    typedef enum logic {
        FP_MUL,
        FP_ADD
    } t_fp_op;

    typedef struct packed {
        logic   go;
        t_fp_op op;
    } t_fp_req;

    // Biased exponent as used in arithmetic: subnormals and zero count as one.
    function automatic logic [10:0] fp_bexp(input logic [63:0] x);
        return (x[62:52] == 11'd0) ? 11'd1 : x[62:52];
    endfunction

    // Significand with the hidden bit made explicit.
    function automatic logic [52:0] fp_mant(input logic [63:0] x);
        return {(x[62:52] != 11'd0), x[51:0]};
    endfunction

    function automatic logic fp_is_nan(input logic [63:0] x);
        return (x[62:52] == 11'h7FF) && (x[51:0] != 52'd0);
    endfunction

    function automatic logic fp_is_inf(input logic [63:0] x);
        return (x[62:52] == 11'h7FF) && (x[51:0] == 52'd0);
    endfunction

    function automatic logic fp_is_zero(input logic [63:0] x);
        return x[62:0] == 63'd0;
    endfunction

endpackage
`default_nettype wire

### design/double_matrix_multiply_accumulate.sv
// Double matrix multiply-accumulate C = C + A*B over one shared iterative FP unit.
// Load: one item per cycle while busy is low; busy is low until the n*n-th item of a load is taken.
// Compute: for each C element, C is read and loaded, then for each k the A and B elements
// are read, multiplied and added into the sum in the one FP unit; special operands finish
// early, normal ones pass the shift-add multiply and the alignment and normalization shifts.
// Results leave on o_valid, one per element in column-major order, and cannot be stalled.
// Reset (synchronous, active low) sets matrix_size to 8, clears the load count, idles.
`default_nettype none
`include "assert_macros.svh"
module double_matrix_multiply_accumulate (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [63:0] i_a_bits,
    input  wire logic [63:0] i_b_bits,
    input  wire logic [63:0] i_c_bits,
    input  wire logic        i_cfg_we,
    input  wire logic [3:0]  i_cfg_data,
    output logic             o_valid,
    output logic [63:0]      o_result_bits,
    output logic             o_last_result
);
    import dmma_pkg::*;

    t_state          r_state, n_state;
    logic [3:0]      r_size;
    logic [6:0]      r_cnt;
    logic [IW-1:0]   r_i, n_i, r_j, n_j, r_k, n_k;
    logic [63:0]     r_acc, n_acc;
    logic [63:0]     r_prod, n_prod;
    logic [63:0]     r_qa, r_qb, r_qc;
    logic [63:0]     r_mem_a [DEPTH];
    logic [63:0]     r_mem_b [DEPTH];
    logic [63:0]     r_mem_c [DEPTH];

    logic [3:0]      eff;
    logic [IW-1:0]   eff_m1;
    logic [6:0]      total;
    logic [6:0]      load_e;
    logic            accept;
    logic [AW-1:0]   addr_a, addr_b, addr_c;
    logic            last_i, last_j, last_k;
    t_fp_req         fp_req;
    logic [63:0]     fp_a, fp_b;
    logic            fp_done;
    logic [63:0]     fp_res;

    // Effective matrix size and load bookkeeping.
    assign eff    = (r_size == 4'd0) ? 4'd1 : ((r_size > 4'(MAX_N)) ? 4'(MAX_N) : r_size);
    assign eff_m1 = IW'(eff - 4'd1);
    assign total  = 7'(eff * eff);
    assign load_e = (r_cnt >= total) ? 7'd0 : r_cnt;
    assign accept = start && !busy;
    assign busy   = (r_state != ST_IDLE);

    assign last_i = (r_i == eff_m1);
    assign last_j = (r_j == eff_m1);
    assign last_k = (r_k == eff_m1);

    // Column-major addresses with stride n.
    assign addr_a = AW'(7'(r_i) + 7'(r_k) * 7'(eff));
    assign addr_b = AW'(7'(r_k) + 7'(r_j) * 7'(eff));
    assign addr_c = AW'(7'(r_i) + 7'(r_j) * 7'(eff));

    // Operand stores: written on each accepted item, read through a register.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mem_a[load_e[AW-1:0]] <= i_a_bits;
            r_mem_b[load_e[AW-1:0]] <= i_b_bits;
            r_mem_c[load_e[AW-1:0]] <= i_c_bits;
        end
        r_qa <= r_mem_a[addr_a];
        r_qb <= r_mem_b[addr_b];
        r_qc <= r_mem_c[addr_c];
    end

    // Configuration and load counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= 4'd8;
            r_cnt  <= '0;
        end else if (i_cfg_we) begin
            r_size <= i_cfg_data;
            r_cnt  <= '0;
        end else if (accept) begin
            r_cnt <= ((load_e + 7'd1) >= total) ? 7'd0 : (load_e + 7'd1);
        end
    end

    // Sequencer registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_i    <= n_i;
        r_j    <= n_j;
        r_k    <= n_k;
        r_acc  <= n_acc;
        r_prod <= n_prod;
    end

    // Sequencer: walks j, i, k and drives the shared FP unit.
    always_comb begin
        n_state    = r_state;
        n_i        = r_i;
        n_j        = r_j;
        n_k        = r_k;
        n_acc      = r_acc;
        n_prod     = r_prod;
        fp_req.go  = 1'b0;
        fp_req.op  = FP_MUL;
        fp_a       = r_qa;
        fp_b       = r_qb;

        unique case (r_state)
            ST_IDLE: begin
                if (accept && ((load_e + 7'd1) >= total)) begin
                    n_i     = '0;
                    n_j     = '0;
                    n_state = ST_RDC;
                end
            end
            ST_RDC: begin
                n_state = ST_LDC;
            end
            ST_LDC: begin
                n_acc   = r_qc;
                n_k     = '0;
                n_state = ST_RDAB;
            end
            ST_RDAB: begin
                n_state = ST_MUL;
            end
            ST_MUL: begin
                fp_req.go = 1'b1;
                n_state   = ST_MWAIT;
            end
            ST_MWAIT: begin
                if (fp_done) begin
                    n_prod  = fp_res;
                    n_state = ST_ADD;
                end
            end
            ST_ADD: begin
                fp_req.go = 1'b1;
                fp_req.op = FP_ADD;
                fp_a      = r_acc;
                fp_b      = r_prod;
                n_state   = ST_AWAIT;
            end
            ST_AWAIT: begin
                fp_a = r_acc;
                fp_b = r_prod;
                if (fp_done) begin
                    n_acc = fp_res;
                    if (last_k) begin
                        n_state = ST_OUT;
                    end else begin
                        n_k     = r_k + 1'b1;
                        n_state = ST_RDAB;
                    end
                end
            end
            ST_OUT: begin
                if (last_i) begin
                    n_i = '0;
                    n_j = r_j + 1'b1;
                end else begin
                    n_i = r_i + 1'b1;
                end
                n_state = (last_i && last_j) ? ST_IDLE : ST_RDC;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    dmma_fpu u_fpu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (fp_req),
        .i_a      (fp_a),
        .i_b      (fp_b),
        .o_done   (fp_done),
        .o_result (fp_res)
    );

    // Result port.
    assign o_valid       = (r_state == ST_OUT);
    assign o_result_bits = r_acc;
    assign o_last_result = o_valid && last_i && last_j;

    // Checks.
    `DMMA_ASSERT(a_cnt_range, i_clk, i_rst_n, r_cnt < 7'(DEPTH))
    `DMMA_ASSERT(a_valid_busy, i_clk, i_rst_n, o_valid |-> busy)
    `DMMA_ASSERT_NEXT(a_last_idle, i_clk, i_rst_n, o_valid && o_last_result, !busy)
    `DMMA_ASSERT_NEXT(a_fp_single, i_clk, i_rst_n, fp_req.go, !fp_req.go)

endmodule
`default_nettype wire

### design/dmma_fpu.sv
// Iterative double-precision unit: multiply or add, rounded to nearest-even.
`default_nettype none
module dmma_fpu (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire dmma_pkg::t_fp_req i_req,
    input  wire logic [63:0]      i_a,
    input  wire logic [63:0]      i_b,
    output logic                  o_done,
    output logic [63:0]           o_result
);
    import dmma_pkg::*;

    t_fp_state          r_fs, n_fs;
    logic               r_sign, n_sign;
    logic               r_zsign, n_zsign;
    logic               r_sub, n_sub;
    logic signed [13:0] r_exp, n_exp;
    logic [107:0]       r_m, n_m;
    logic [107:0]       r_small, n_small;
    logic [52:0]        r_ma, n_ma;
    logic [10:0]        r_d, n_d;
    logic [5:0]         r_cnt, n_cnt;
    logic [63:0]        r_res, n_res;

    logic        sa, sb, a_big;
    logic [10:0] ea, eb;
    logic [52:0] ma, mb;
    logic [53:0] mul_sum;
    logic [108:0] add_sum;
    logic [52:0] rnd_mant, rnd_out;
    logic        rnd_inc;
    logic [53:0] rnd_sum;
    logic signed [13:0] rnd_exp;

    // State and datapath registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fs <= FS_IDLE;
        end else begin
            r_fs <= n_fs;
        end
        r_sign  <= n_sign;
        r_zsign <= n_zsign;
        r_sub   <= n_sub;
        r_exp   <= n_exp;
        r_m     <= n_m;
        r_small <= n_small;
        r_ma    <= n_ma;
        r_d     <= n_d;
        r_cnt   <= n_cnt;
        r_res   <= n_res;
    end

    // Sequencer and the shared datapath.
    always_comb begin
        n_fs    = r_fs;
        n_sign  = r_sign;
        n_zsign = r_zsign;
        n_sub   = r_sub;
        n_exp   = r_exp;
        n_m     = r_m;
        n_small = r_small;
        n_ma    = r_ma;
        n_d     = r_d;
        n_cnt   = r_cnt;
        n_res   = r_res;
        o_done  = 1'b0;

        sa = i_a[63];
        sb = i_b[63];
        ea = fp_bexp(i_a);
        eb = fp_bexp(i_b);
        ma = fp_mant(i_a);
        mb = fp_mant(i_b);
        a_big = {ea, ma} >= {eb, mb};

        mul_sum = {1'b0, r_m[105:53]} + (r_m[0] ? {1'b0, r_ma} : 54'd0);
        add_sum = r_sub ? ({1'b0, r_m} - {1'b0, r_small}) : ({1'b0, r_m} + {1'b0, r_small});

        rnd_mant = r_m[107:55];
        rnd_inc  = r_m[54] & ((|r_m[53:0]) | rnd_mant[0]);
        rnd_sum  = {1'b0, rnd_mant} + {53'd0, rnd_inc};
        if (rnd_sum[53]) begin
            rnd_out = rnd_sum[53:1];
            rnd_exp = r_exp + 14'sd1;
        end else begin
            rnd_out = rnd_sum[52:0];
            rnd_exp = r_exp;
        end

        unique case (r_fs)
            FS_IDLE: begin
                if (i_req.go) begin
                    n_fs = FS_DONE;
                    if (fp_is_nan(i_a)) begin
                        n_res = i_a | QNAN_BIT;
                    end else if (fp_is_nan(i_b)) begin
                        n_res = i_b | QNAN_BIT;
                    end else if (i_req.op == FP_MUL) begin
                        if ((fp_is_inf(i_a) && fp_is_zero(i_b)) ||
                            (fp_is_zero(i_a) && fp_is_inf(i_b))) begin
                            n_res = DEF_NAN;
                        end else if (fp_is_inf(i_a) || fp_is_inf(i_b)) begin
                            n_res = {sa ^ sb, 11'h7FF, 52'd0};
                        end else if (fp_is_zero(i_a) || fp_is_zero(i_b)) begin
                            n_res = {sa ^ sb, 63'd0};
                        end else begin
                            n_sign = sa ^ sb;
                            n_ma   = ma;
                            n_m    = {55'd0, mb};
                            n_exp  = 14'(ea) + 14'(eb) - 14'sd1020;
                            n_cnt  = '0;
                            n_fs   = FS_MUL;
                        end
                    end else begin
                        if (fp_is_inf(i_a) && fp_is_inf(i_b) && (sa != sb)) begin
                            n_res = DEF_NAN;
                        end else if (fp_is_inf(i_a)) begin
                            n_res = i_a;
                        end else if (fp_is_inf(i_b)) begin
                            n_res = i_b;
                        end else begin
                            n_sub   = sa ^ sb;
                            n_zsign = sa & sb;
                            if (a_big) begin
                                n_sign  = sa;
                                n_m     = {ma, 55'd0};
                                n_small = {mb, 55'd0};
                                n_exp   = 14'(ea);
                                n_d     = ea - eb;
                            end else begin
                                n_sign  = sb;
                                n_m     = {mb, 55'd0};
                                n_small = {ma, 55'd0};
                                n_exp   = 14'(eb);
                                n_d     = eb - ea;
                            end
                            n_fs = FS_ALIGN;
                        end
                    end
                end
            end
            FS_MUL: begin
                // One multiplier bit per cycle, shift-add.
                n_m   = {2'b00, mul_sum, r_m[52:1]};
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'd52) begin
                    n_fs = FS_NORM;
                end
            end
            FS_ALIGN: begin
                // Shift the smaller operand right, folding lost bits into a sticky bit.
                if (r_d == 11'd0) begin
                    n_fs = FS_SUM;
                end else if (r_d >= 11'd110) begin
                    n_small = {107'd0, |r_small};
                    n_d     = '0;
                end else if (r_d >= 11'd8) begin
                    n_small = {8'd0, r_small[107:9], r_small[8] | (|r_small[7:0])};
                    n_d     = r_d - 11'd8;
                end else begin
                    n_small = {1'b0, r_small[107:2], r_small[1] | r_small[0]};
                    n_d     = r_d - 11'd1;
                end
            end
            FS_SUM: begin
                if (add_sum == 109'd0) begin
                    n_res = {r_zsign, 63'd0};
                    n_fs  = FS_DONE;
                end else if (add_sum[108]) begin
                    n_m   = {add_sum[108:2], add_sum[1] | add_sum[0]};
                    n_exp = r_exp + 14'sd1;
                    n_fs  = FS_NORM;
                end else begin
                    n_m  = add_sum[107:0];
                    n_fs = FS_NORM;
                end
            end
            FS_NORM: begin
                // Left shift until the leading one is on top or the exponent bottoms out.
                if (r_m[107] || (r_exp <= 14'sd1)) begin
                    n_fs = FS_DENORM;
                end else if ((r_exp > 14'sd8) && (r_m[107:100] == 8'd0)) begin
                    n_m   = {r_m[99:0], 8'd0};
                    n_exp = r_exp - 14'sd8;
                end else begin
                    n_m   = {r_m[106:0], 1'b0};
                    n_exp = r_exp - 14'sd1;
                end
            end
            FS_DENORM: begin
                // Right shift into the subnormal range, keeping a sticky bit.
                if (r_exp >= 14'sd1) begin
                    n_fs = FS_ROUND;
                end else if (r_exp < -14'sd120) begin
                    n_m   = {107'd0, |r_m};
                    n_exp = 14'sd1;
                end else if (r_exp <= -14'sd7) begin
                    n_m   = {8'd0, r_m[107:9], r_m[8] | (|r_m[7:0])};
                    n_exp = r_exp + 14'sd8;
                end else begin
                    n_m   = {1'b0, r_m[107:2], r_m[1] | r_m[0]};
                    n_exp = r_exp + 14'sd1;
                end
            end
            FS_ROUND: begin
                if (!rnd_out[52]) begin
                    n_res = {r_sign, 11'd0, rnd_out[51:0]};
                end else if (rnd_exp >= 14'sd2047) begin
                    n_res = {r_sign, 11'h7FF, 52'd0};
                end else begin
                    n_res = {r_sign, rnd_exp[10:0], rnd_out[51:0]};
                end
                n_fs = FS_DONE;
            end
            FS_DONE: begin
                o_done = 1'b1;
                n_fs   = FS_IDLE;
            end
            default: begin
                n_fs = FS_IDLE;
            end
        endcase
    end

    assign o_result = r_res;

endmodule
`default_nettype wire

### bench/testbench.sv
// Self-checking testbench for the double matrix multiply-accumulate block.
`default_nettype none
module testbench;
    import dmma_pkg::*;

    typedef struct {
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] c;
    } t_item;

    typedef struct {
        logic [63:0] bits;
        logic        last;
    } t_elem;

    localparam logic [63:0] POS_INF  = 64'h7FF0_0000_0000_0000;
    localparam logic [63:0] NEG_INF  = 64'hFFF0_0000_0000_0000;
    localparam logic [63:0] QNAN     = 64'h7FF8_0000_0000_0000;
    localparam logic [63:0] NEG_ZERO = 64'h8000_0000_0000_0000;
    localparam logic [63:0] MAX_FIN  = 64'h7FEF_FFFF_FFFF_FFFF;
    localparam logic [63:0] MIN_SUB  = 64'h0000_0000_0000_0001;
    localparam logic [63:0] ONE      = 64'h3FF0_0000_0000_0000;
    localparam int          DRAIN_CYCLES = 400;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [63:0] i_a_bits = '0;
    logic [63:0] i_b_bits = '0;
    logic [63:0] i_c_bits = '0;
    logic        i_cfg_we = 1'b0;
    logic [3:0]  i_cfg_data = '0;
    logic        o_valid;
    logic [63:0] o_result_bits;
    logic        o_last_result;

    // Pending items, expected result elements and shadow state of the block.
    t_item  pending_q[$];
    t_elem  product_q[$];
    real    a_mat[DEPTH];
    real    b_mat[DEPTH];
    real    c_mat[DEPTH];
    int     load_cnt = 0;
    int     size_reg = MAX_N;
    bit     took = 1'b0;
    bit     hold_off = 1'b0;
    int     idle_pct = 0;
    int     errors = 0;
    int     sent = 0;

    double_matrix_multiply_accumulate u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_a_bits     (i_a_bits),
        .i_b_bits     (i_b_bits),
        .i_c_bits     (i_c_bits),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .o_valid      (o_valid),
        .o_result_bits(o_result_bits),
        .o_last_result(o_last_result)
    );

    always #1 i_clk = ~i_clk;

    // Effective size after clamping of the register value.
    function automatic int eff_size();
        if (size_reg == 0) return 1;
        if (size_reg > MAX_N) return MAX_N;
        return size_reg;
    endfunction

    // Store one item and, when the load completes, compute C + A*B element by element.
    task automatic predict_mac(input t_item it);
        int    n;
        int    total;
        int    e;
        real   acc;
        real   prod;
        t_elem r;
        n = eff_size();
        total = n * n;
        e = load_cnt;
        if (e >= total) e = 0;
        a_mat[e] = $bitstoreal(it.a);
        b_mat[e] = $bitstoreal(it.b);
        c_mat[e] = $bitstoreal(it.c);
        e++;
        if (e < total) begin
            load_cnt = e;
        end else begin
            load_cnt = 0;
            for (int j = 0; j < n; j++) begin
                for (int i = 0; i < n; i++) begin
                    acc = c_mat[i + j * n];
                    for (int k = 0; k < n; k++) begin
                        prod = a_mat[i + k * n] * b_mat[k + j * n];
                        acc = acc + prod;
                    end
                    r.bits = $realtobits(acc);
                    r.last = (i + j * n + 1 == total);
                    product_q.push_back(r);
                end
            end
        end
    endtask

    // Acceptance of items and checking of results at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy) begin
            predict_mac(pending_q[0]);
            took = 1'b1;
        end
        if (i_rst_n && o_valid) begin
            if (product_q.size() == 0) begin
                $display("%0t: unexpected result %h last %b", $time, o_result_bits,
                         o_last_result);
                errors++;
            end else begin
                if (o_result_bits !== product_q[0].bits) begin
                    $display("%0t: result_bits expected %h actual %h", $time,
                             product_q[0].bits, o_result_bits);
                    errors++;
                end
                if (o_last_result !== product_q[0].last) begin
                    $display("%0t: last_result expected %b actual %b", $time,
                             product_q[0].last, o_last_result);
                    errors++;
                end
                void'(product_q.pop_front());
            end
        end
    end

    // Driver: present the oldest pending item at the falling edge, with random gaps.
    always @(negedge i_clk) begin
        if (took) begin
            void'(pending_q.pop_front());
            took = 1'b0;
        end
        if (i_rst_n && pending_q.size() > 0 && !hold_off &&
            $urandom_range(0, 99) >= idle_pct) begin
            start = 1'b1;
            i_a_bits = pending_q[0].a;
            i_b_bits = pending_q[0].b;
            i_c_bits = pending_q[0].c;
        end else begin
            start = 1'b0;
        end
    end

    // Random operand: raw patterns, small exact values, subnormals, moderate normal values, special encodings and zero.
    function automatic logic [63:0] rand_fp();
        case ($urandom_range(0, 9))
            0, 1, 2: return {$urandom, $urandom};
            3, 4, 5: return $realtobits((real'($urandom_range(0, 2000)) - 1000.0) / 8.0);
            6: return {$urandom_range(0, 1) == 1, 11'd0, 20'($urandom_range(0, 1048575)),
                       $urandom};
            7: return {$urandom_range(0, 1) == 1, 11'd1023 + 11'($urandom_range(0, 40)),
                       20'($urandom), $urandom};
            8: begin
                case ($urandom_range(0, 5))
                    0: return POS_INF;
                    1: return NEG_INF;
                    2: return QNAN;
                    3: return NEG_ZERO;
                    4: return MAX_FIN;
                    default: return MIN_SUB;
                endcase
            end
            default: return 64'd0;
        endcase
    endfunction

    task automatic add_item(input logic [63:0] a, input logic [63:0] b,
                            input logic [63:0] c);
        t_item it;
        it.a = a;
        it.b = b;
        it.c = c;
        pending_q.push_back(it);
        sent++;
    endtask

    task automatic add_load(input int n);
        for (int e = 0; e < n * n; e++) add_item(rand_fp(), rand_fp(), rand_fp());
    endtask

    // Wait until every item is taken, every result has come and the block has settled.
    task automatic wait_idle();
        wait (pending_q.size() == 0);
        @(posedge i_clk);
        wait (product_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_size(input logic [3:0] v);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_data = v;
        @(posedge i_clk);
        size_reg = v;
        load_cnt = 0;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    initial begin
        int n;
        int phase;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part: special operands, with single-element matrices first.
        write_size(4'd1);
        add_item(ONE, ONE, ONE);
        add_item(POS_INF, 64'd0, ONE);
        add_item(QNAN, ONE, 64'd0);
        add_item(MAX_FIN, MAX_FIN, 64'd0);
        add_item(MIN_SUB, ONE, MIN_SUB);
        add_item(NEG_ZERO, 64'd0, NEG_ZERO);
        add_item(POS_INF, ONE, NEG_INF);
        add_item(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        wait_idle();
        // A size of zero acts as one.
        write_size(4'd0);
        add_item(64'h4000_0000_0000_0000, 64'h4008_0000_0000_0000, ONE);
        add_item(MIN_SUB, MIN_SUB, NEG_ZERO);
        wait_idle();
        write_size(4'd2);
        add_item(ONE, 64'h4000_0000_0000_0000, 64'd0);
        add_item(64'hC000_0000_0000_0000, MAX_FIN, ONE);
        add_item(MAX_FIN, ONE, MIN_SUB);
        add_item(64'h0010_0000_0000_0000, NEG_INF, 64'd0);
        wait_idle();
        // A partial load is dropped by a size write.
        write_size(4'd3);
        add_item(QNAN, QNAN, QNAN);
        add_item(POS_INF, POS_INF, POS_INF);
        wait_idle();

        // Random part in phases with different sender idling.
        phase = 0;
        while (sent < 226) begin
            case (phase % 3)
                0: idle_pct = 0;
                1: idle_pct = 45;
                default: idle_pct = 7;
            endcase
            if (phase == 2) n = 8;
            else if (phase == 6) n = 15;
            else if (phase == 4) n = 0;
            else n = $urandom_range(1, 5);
            write_size(4'(n));
            n = eff_size();
            for (int l = 0; l < 3 && (n * n) * l < 40; l++) add_load(n);
            if (phase == 3) begin
                // Let everything drain before the next load goes in.
                wait (pending_q.size() == 0);
                hold_off = 1'b1;
                wait (product_q.size() == 0);
                add_load(n);
                @(negedge i_clk);
                hold_off = 1'b0;
            end
            if (phase == 5) add_item(rand_fp(), rand_fp(), rand_fp());
            wait_idle();
            phase++;
        end

        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Watchdog for a hung run.
    initial begin
        #3000000;
        $display("Regression FAIL");
        $finish;
    end
endmodule
`default_nettype wire
